/* design/fss_pkg.sv */
// shared types, constants and helpers for the fuzzy subsequence scorer
`timescale 1ns / 1ps

package fss_pkg;

   // configuration port geometry: five 64-bit registers at 8-byte spacing
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int PATTERN_WORDS = 4;
   localparam int LENGTH_W = 6;

   typedef enum logic [2:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PATTERN_WORD_0 = 3'd1,
      REG_PATTERN_WORD_1 = 3'd2,
      REG_PATTERN_WORD_2 = 3'd3,
      REG_PATTERN_WORD_3 = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_NONE        = 2'd0,
      KIND_SUBSEQUENCE = 2'd1,
      KIND_SUBSTRING   = 2'd2,
      KIND_EXACT       = 2'd3
   } match_kind_type;

   localparam logic [10:0] SCORE_EXACT     = 11'd500;
   localparam logic [10:0] SCORE_SUBSTRING = 11'd300;
   localparam logic [10:0] SCORE_NONE      = 11'd0;
   localparam logic [10:0] SCORE_MAX       = 11'd2047;
   localparam logic [5:0]  GAIN_HIT        = 6'd12;
   localparam logic [5:0]  GAIN_ADJACENT   = 6'd10;
   localparam logic [5:0]  GAIN_BOUNDARY   = 6'd8;
   localparam logic [5:0]  POS_BONUS_LIMIT = 6'd12;
   localparam logic [5:0]  POS_SATURATE    = 6'd63;

   localparam logic [7:0] CHAR_SLASH      = 8'h2f;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_DASH       = 8'h2d;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5a;
   localparam logic [7:0] CASE_OFFSET     = 8'h20;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
      logic       empty_text;
   } req_payload_type;

   typedef struct packed {
      logic [10:0]    score;
      match_kind_type match_kind;
   } rsp_payload_type;

   // per-cycle command to every cell
   typedef struct packed {
      logic advance;
      logic restart;
   } cell_ctrl_type;

   // what one cell hands to the next
   typedef struct packed {
      logic tr;
      logic tok;
      logic ex;
   } cell_link_type;

   // what one cell reports to the top level
   typedef struct packed {
      logic hit;
      logic tr_nx;
      logic tok_nx;
      logic ex_nx;
   } cell_status_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return (c == CHAR_SLASH) || (c == CHAR_UNDERSCORE) ||
             (c == CHAR_DASH) || (c == CHAR_SPACE);
   endfunction

endpackage

/* design/fss_csr.sv */
// configuration register file: pattern length and four pattern words
`timescale 1ns / 1ps

module fss_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [fss_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [fss_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [fss_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready,
   output logic [fss_pkg::LENGTH_W-1:0]           pattern_length,
   output logic [fss_pkg::PATTERN_WORDS-1:0][63:0] pattern_word
);

   logic [fss_pkg::LENGTH_W-1:0]            length_ff;
   logic [fss_pkg::LENGTH_W-1:0]            length_in;
   logic [fss_pkg::PATTERN_WORDS-1:0][63:0] word_ff;
   logic [fss_pkg::PATTERN_WORDS-1:0][63:0] word_in;
   logic                                    wr_en;
   fss_pkg::reg_index_type                  reg_idx;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx = fss_pkg::reg_index_type'(csr_paddr[5:3]);

   always_comb begin
      length_in = length_ff;
      word_in   = word_ff;
      if (wr_en) begin
         case (reg_idx)
            fss_pkg::REG_PATTERN_LENGTH: length_in = csr_pwdata[fss_pkg::LENGTH_W-1:0];
            fss_pkg::REG_PATTERN_WORD_0: word_in[0] = csr_pwdata;
            fss_pkg::REG_PATTERN_WORD_1: word_in[1] = csr_pwdata;
            fss_pkg::REG_PATTERN_WORD_2: word_in[2] = csr_pwdata;
            fss_pkg::REG_PATTERN_WORD_3: word_in[3] = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         fss_pkg::REG_PATTERN_LENGTH:
            csr_prdata = {{(fss_pkg::CSR_DATA_W-fss_pkg::LENGTH_W){1'b0}}, length_ff};
         fss_pkg::REG_PATTERN_WORD_0: csr_prdata = word_ff[0];
         fss_pkg::REG_PATTERN_WORD_1: csr_prdata = word_ff[1];
         fss_pkg::REG_PATTERN_WORD_2: csr_prdata = word_ff[2];
         fss_pkg::REG_PATTERN_WORD_3: csr_prdata = word_ff[3];
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         word_ff   <= '0;
      end else begin
         length_ff <= length_in;
         word_ff   <= word_in;
      end
   end

   assign csr_pready     = 1'b1;
   assign pattern_length = length_ff;
   assign pattern_word   = word_ff;

endmodule

/* design/fss_cell.sv */
// one pattern position: shift-and bit, subsequence token and exact token
`timescale 1ns / 1ps

module fss_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  fss_pkg::cell_ctrl_type   ctrl,
   input  logic [7:0]               text_char,
   input  logic [7:0]               pattern_char,
   input  logic                     active,
   input  logic                     seed,
   input  fss_pkg::cell_link_type   link_in,
   output fss_pkg::cell_link_type   link_out,
   output fss_pkg::cell_status_type status
);

   logic tr_ff, tr_in;
   logic tok_ff, tok_in;
   logic ex_ff, ex_in;
   logic match;

   assign match = active & (text_char == pattern_char);

   // shift-and takes the neighbor's old bit, tokens move on a match
   assign status.tr_nx  = link_in.tr & match;
   assign status.tok_nx = (tok_ff & ~match) | link_in.tok;
   assign status.ex_nx  = link_in.ex;
   assign status.hit    = tok_ff & match;

   assign link_out.tr  = tr_ff;
   assign link_out.tok = tok_ff & match;
   assign link_out.ex  = ex_ff & match;

   always_comb begin
      tr_in  = tr_ff;
      tok_in = tok_ff;
      ex_in  = ex_ff;
      if (ctrl.restart) begin
         tr_in  = 1'b0;
         tok_in = seed;
         ex_in  = seed;
      end else if (ctrl.advance) begin
         tr_in  = status.tr_nx;
         tok_in = status.tok_nx;
         ex_in  = status.ex_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tr_ff  <= 1'b0;
         tok_ff <= seed;
         ex_ff  <= seed;
      end else begin
         tr_ff  <= tr_in;
         tok_ff <= tok_in;
         ex_ff  <= ex_in;
      end
   end

endmodule

/* design/fuzzy_subsequence_scorer.sv */
// top level: fuzzy subsequence scorer with a chain of pattern cells
`timescale 1ns / 1ps

// Scores a text, one byte per transaction on the req channel, against a
// case-folded pattern of up to MAX_PATTERN bytes held in configuration
// registers. A byte is taken every clock cycle: each pattern position is a
// cell that compares the byte in parallel and passes a shift-and bit, a
// greedy subsequence token and an exact-match token to its neighbor, so the
// per-byte work is one compare per cell plus one small add for the running
// score. On the byte marked last_char, or on a transaction marked empty_text,
// one result (score and match_kind) is registered and shown on the rsp
// channel the next cycle; req accepts a new byte as long as that register
// is free or being emptied. Exact match scores 500, contiguous substring
// 300, a complete greedy subsequence the sum of its hit gains, anything
// else 0. Write the configuration only while no text is in flight.

module fuzzy_subsequence_scorer #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // byte stream
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fss_pkg::req_payload_type        req_payload,
   // results
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fss_pkg::rsp_payload_type        rsp_payload,
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fss_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fss_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int IDXW = $clog2(MAX_PATTERN + 1);

   // configuration
   logic [fss_pkg::LENGTH_W-1:0]            pattern_length;
   logic [fss_pkg::PATTERN_WORDS-1:0][63:0] pattern_word;
   logic [IDXW-1:0]                         m_use;

   // handshake
   logic accept;
   logic load;
   logic rsp_valid_ff, rsp_valid_in;
   fss_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   fss_pkg::cell_ctrl_type   ctrl;

   // chain
   logic [7:0]                      char_fold;
   fss_pkg::cell_link_type          link [MAX_PATTERN+1];
   fss_pkg::cell_status_type        status [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]          hit_vec;
   logic [MAX_PATTERN-1:0]          tr_nx_vec;
   logic [MAX_PATTERN-1:0]          last_oh;
   logic [MAX_PATTERN:0]            tok_all;
   logic [MAX_PATTERN:0]            ex_all;
   logic [MAX_PATTERN:0]            at_len;

   // scoring state kept outside the cells
   logic [10:0] score_ff, score_in, score_nx;
   logic [5:0]  pos_ff, pos_in, pos_nx;
   logic        prev_hit_ff, prev_hit_in;
   logic        prev_bnd_ff, prev_bnd_in;
   logic        seen_ff, seen_in, seen_nx;
   logic        tok_end_ff, tok_end_in, tok_end_nx;
   logic        ex_end_ff, ex_end_in, ex_end_nx;
   logic        hit;
   logic [5:0]  gain;
   logic [11:0] score_sum;
   logic        exact_now;
   logic        done_now;

   fss_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .pattern_length (pattern_length),
      .pattern_word   (pattern_word)
   );

   // lengths above the chain size are clamped to it
   assign m_use = (pattern_length > fss_pkg::LENGTH_W'(MAX_PATTERN)) ?
                  IDXW'(MAX_PATTERN) : pattern_length[IDXW-1:0];

   // one transaction in, output register parts the two sides
   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign load        = accept & (req_payload.last_char | req_payload.empty_text);
   assign ctrl.advance = accept & ~req_payload.empty_text;
   assign ctrl.restart = load;

   assign char_fold = fss_pkg::fold_char(req_payload.text_char);

   // head of the chain: shift-and always feeds a one, tokens are seeded inside
   assign link[0] = '{tr: 1'b1, tok: 1'b0, ex: 1'b0};

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      fss_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .text_char    (char_fold),
         .pattern_char (fss_pkg::fold_char(pattern_word[j/8][(j%8)*8 +: 8])),
         .active       (m_use > IDXW'(j)),
         .seed         (j == 0),
         .link_in      (link[j]),
         .link_out     (link[j+1]),
         .status       (status[j])
      );
      assign hit_vec[j]   = status[j].hit;
      assign tr_nx_vec[j] = status[j].tr_nx;
      assign tok_all[j]   = status[j].tok_nx;
      assign ex_all[j]    = status[j].ex_nx;
      // marks the last pattern position in use
      assign last_oh[j]   = (m_use == IDXW'(j + 1));
   end

   for (genvar k = 0; k <= MAX_PATTERN; k++) begin : g_len
      assign at_len[k] = (m_use == IDXW'(k));
   end

   // tokens that run off the end of a full-length chain
   assign tok_end_nx = tok_end_ff | link[MAX_PATTERN].tok;
   assign ex_end_nx  = link[MAX_PATTERN].ex;
   assign tok_all[MAX_PATTERN] = tok_end_nx;
   assign ex_all[MAX_PATTERN]  = ex_end_nx;

   // greedy subsequence gain for this byte
   assign hit = |hit_vec;
   always_comb begin
      gain = fss_pkg::GAIN_HIT;
      if (prev_hit_ff) begin
         gain = gain + fss_pkg::GAIN_ADJACENT;
      end
      if (prev_bnd_ff) begin
         gain = gain + fss_pkg::GAIN_BOUNDARY;
      end
      if (pos_ff < fss_pkg::POS_BONUS_LIMIT) begin
         gain = gain + (fss_pkg::POS_BONUS_LIMIT - pos_ff);
      end
   end

   assign score_sum = {1'b0, score_ff} + {6'd0, gain};
   always_comb begin
      score_nx = score_ff;
      if (hit) begin
         score_nx = (score_sum > {1'b0, fss_pkg::SCORE_MAX}) ?
                    fss_pkg::SCORE_MAX : score_sum[10:0];
      end
   end

   assign pos_nx    = (pos_ff < fss_pkg::POS_SATURATE) ? pos_ff + 6'd1 : fss_pkg::POS_SATURATE;
   assign seen_nx   = seen_ff | (|(tr_nx_vec & last_oh));
   assign exact_now = |(ex_all & at_len);
   assign done_now  = |(tok_all & at_len);

   // result priority: empty text or empty pattern, exact, substring, complete subsequence, none
   always_comb begin
      rsp_payload_in = '{score: fss_pkg::SCORE_NONE, match_kind: fss_pkg::KIND_NONE};
      if (req_payload.empty_text || m_use == '0) begin
         rsp_payload_in = '{score: fss_pkg::SCORE_NONE, match_kind: fss_pkg::KIND_NONE};
      end else if (exact_now) begin
         rsp_payload_in = '{score: fss_pkg::SCORE_EXACT, match_kind: fss_pkg::KIND_EXACT};
      end else if (seen_nx) begin
         rsp_payload_in = '{score: fss_pkg::SCORE_SUBSTRING,
                            match_kind: fss_pkg::KIND_SUBSTRING};
      end else if (done_now) begin
         rsp_payload_in = '{score: score_nx, match_kind: fss_pkg::KIND_SUBSEQUENCE};
      end
   end

   // state update: restart after a result, step on a plain byte
   always_comb begin
      score_in    = score_ff;
      pos_in      = pos_ff;
      prev_hit_in = prev_hit_ff;
      prev_bnd_in = prev_bnd_ff;
      seen_in     = seen_ff;
      tok_end_in  = tok_end_ff;
      ex_end_in   = ex_end_ff;
      if (ctrl.restart) begin
         score_in    = '0;
         pos_in      = '0;
         prev_hit_in = 1'b0;
         prev_bnd_in = 1'b1;
         seen_in     = 1'b0;
         tok_end_in  = 1'b0;
         ex_end_in   = 1'b0;
      end else if (ctrl.advance) begin
         score_in    = score_nx;
         pos_in      = pos_nx;
         prev_hit_in = hit;
         prev_bnd_in = fss_pkg::is_separator(char_fold);
         seen_in     = seen_nx;
         tok_end_in  = tok_end_nx;
         ex_end_in   = ex_end_nx;
      end
   end

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff     <= '0;
         pos_ff       <= '0;
         prev_hit_ff  <= 1'b0;
         prev_bnd_ff  <= 1'b1;
         seen_ff      <= 1'b0;
         tok_end_ff   <= 1'b0;
         ex_end_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         score_ff     <= score_in;
         pos_ff       <= pos_in;
         prev_hit_ff  <= prev_hit_in;
         prev_bnd_ff  <= prev_bnd_in;
         seen_ff      <= seen_in;
         tok_end_ff   <= tok_end_in;
         ex_end_ff    <= ex_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, held while the result waits
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // exactly one subsequence token lives in the chain or its end sink
   a_tok_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(tok_all))
      else $error("subsequence token lost or duplicated");

   // at most one exact-match token
   a_ex_onehot0 : assert property (@(posedge clock) disable iff (reset)
      $onehot0(ex_all))
      else $error("exact-match token duplicated");

   // a byte that ends no text never raises a result
   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      accept && !req_payload.last_char && !req_payload.empty_text && !rsp_valid_ff
      |=> !rsp_valid_ff)
      else $error("result produced without end of text");

endmodule

/* tb/tb.sv */
// self-checking testbench for the fuzzy subsequence scorer
`timescale 1ns / 1ps

// Streams candidate texts, one byte per transaction, into the scorer under a
// series of pattern settings and checks every score against an in-bench
// scoring model. The model is the same algorithm as the block: an exact-match
// flag, a shift-and vector for contiguous substrings and a greedy subsequence
// with hit gains. Each setting is written over the APB-style port while the
// block is idle. The run starts with a short directed list (empty text flag,
// exact, substring, subsequence, no match, aborted text, byte extremes),
// then moves to random texts that are mostly well formed against the
// current pattern, with some noise. Both sides idle in random bursts, the
// receiver holds off once for a long stretch, and the last part runs at
// full rate.

module tb;

   localparam int MAX_PATTERN   = 32;
   localparam int ITEM_TARGET   = 1850;
   localparam int PHASE_ITEMS   = 110;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   // score values, gains and limits of the scoring, kept apart from the package
   localparam int POINTS_EXACT     = 500;
   localparam int POINTS_SUBSTRING = 300;
   localparam int POINTS_CEILING   = 2047;
   localparam int HIT_POINTS       = 12;
   localparam int ADJACENT_POINTS  = 10;
   localparam int BOUNDARY_POINTS  = 8;
   localparam int EARLY_LIMIT      = 12;
   localparam int POSITION_CEILING = 63;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   fss_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   fss_pkg::rsp_payload_type rsp_payload;

   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [fss_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [fss_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [fss_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   fuzzy_subsequence_scorer #(.MAX_PATTERN(MAX_PATTERN)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // scoring model: configuration copy and per-text state
   // ---------------------------------------------------------------
   logic [5:0]  pattern_len = '0;
   logic [63:0] pattern_words [fss_pkg::PATTERN_WORDS] = '{default: '0};

   int          greedy_progress;
   int          greedy_score;
   bit          last_was_hit;
   bit          last_was_separator;
   int          chars_seen;
   logic [31:0] shift_and_vec;
   bit          substring_found;
   bit          exact_still;

   fss_pkg::rsp_payload_type expected_scores [$];
   fss_pkg::req_payload_type pending_chars [$];

   int chars_queued = 0;
   int chars_taken = 0;
   int results_checked = 0;
   int error_count = 0;
   int settings_used = 0;
   int kind_seen [4] = '{default: 0};

   // idling controls, set by the stimulus process
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int holds_asked = 0;

   string ALPHABET = "abcdeABCDE/_- ";

   function automatic logic [7:0] lower_case(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return c + 8'd32;
      return c;
   endfunction

   function automatic bit separator_char(input logic [7:0] c);
      return c == "/" || c == "_" || c == "-" || c == " ";
   endfunction

   function automatic logic [7:0] pattern_char(input int k);
      return lower_case(pattern_words[(k >> 3) & 3][(k & 7) * 8 +: 8]);
   endfunction

   // lengths above the pattern store behave as a full pattern
   function automatic int used_length();
      return (pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len);
   endfunction

   task automatic restart_text();
      greedy_progress    = 0;
      greedy_score       = 0;
      last_was_hit       = 1'b0;
      last_was_separator = 1'b1;
      chars_seen         = 0;
      shift_and_vec      = '0;
      substring_found    = 1'b0;
      exact_still        = 1'b1;
   endtask

   // advances the model by one accepted byte and queues any score it gives
   task automatic score_text_char(input fss_pkg::req_payload_type t);
      logic [7:0]               c;
      logic [31:0]              hits;
      int                       m;
      int                       pos;
      int                       gain;
      fss_pkg::rsp_payload_type r;
      r.score = '0;
      r.match_kind = fss_pkg::KIND_NONE;
      if (t.empty_text) begin
         // empty text wins over last_char and drops any partial text
         restart_text();
         expected_scores = {expected_scores, r};
         return;
      end
      c = lower_case(t.text_char);
      m = used_length();
      pos = chars_seen;

      if (pos >= m || c != pattern_char(pos)) exact_still = 1'b0;

      hits = '0;
      for (int j = 0; j < m; j++) begin
         if (pattern_char(j) == c) hits[j] = 1'b1;
      end
      shift_and_vec = ((shift_and_vec << 1) | 32'd1) & hits;
      if (m > 0 && shift_and_vec[m-1]) substring_found = 1'b1;

      if (greedy_progress < m && c == pattern_char(greedy_progress)) begin
         gain = HIT_POINTS;
         if (last_was_hit) gain += ADJACENT_POINTS;
         if (last_was_separator) gain += BOUNDARY_POINTS;
         if (pos < EARLY_LIMIT) gain += EARLY_LIMIT - pos;
         greedy_score += gain;
         if (greedy_score > POINTS_CEILING) greedy_score = POINTS_CEILING;
         greedy_progress++;
         last_was_hit = 1'b1;
      end else begin
         last_was_hit = 1'b0;
      end
      last_was_separator = separator_char(c);
      chars_seen = (pos < POSITION_CEILING) ? pos + 1 : POSITION_CEILING;

      if (!t.last_char) return;

      if (m == 0) begin
         r.match_kind = fss_pkg::KIND_NONE;
      end else if (exact_still && chars_seen == m) begin
         r.score = 11'(POINTS_EXACT);
         r.match_kind = fss_pkg::KIND_EXACT;
      end else if (substring_found) begin
         r.score = 11'(POINTS_SUBSTRING);
         r.match_kind = fss_pkg::KIND_SUBSTRING;
      end else if (greedy_progress == m) begin
         r.score = greedy_score[10:0];
         r.match_kind = fss_pkg::KIND_SUBSEQUENCE;
      end
      expected_scores = {expected_scores, r};
      restart_text();
   endtask

   // ---------------------------------------------------------------
   // driver: presents pending bytes, holds each until accepted
   // ---------------------------------------------------------------
   int                       gap_left = 0;
   bit                       next_valid;
   fss_pkg::req_payload_type next_char;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            score_text_char(req_payload);
            chars_taken++;
         end
         // a new transaction is chosen only when the current one is gone
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            next_char = req_payload;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_chars.size() > 0) begin
               next_valid = 1'b1;
               next_char = pending_chars.pop_front();
               if (req_gaps_on && $urandom_range(0, 5) == 0)
                  gap_left = $urandom_range(1, 12);
            end
            req_valid <= next_valid;
            req_payload <= next_char;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: checks results and drives the receiver stall
   // ---------------------------------------------------------------
   int                       stall_left = 0;
   int                       hold_left = 0;
   int                       holds_done = 0;
   bit                       next_stall;
   fss_pkg::rsp_payload_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_scores.size() == 0) begin
               $error("unexpected result: score %0d, match_kind %0d",
                      rsp_payload.score, rsp_payload.match_kind);
               error_count++;
            end else begin
               want = expected_scores.pop_front();
               if (rsp_payload.score !== want.score) begin
                  $error("score: expected %0d, got %0d", want.score, rsp_payload.score);
                  error_count++;
               end
               if (rsp_payload.match_kind !== want.match_kind) begin
                  $error("match_kind: expected %0d, got %0d",
                         want.match_kind, rsp_payload.match_kind);
                  error_count++;
               end
               kind_seen[want.match_kind]++;
               results_checked++;
            end
         end
         // long hold-off on request, otherwise short random stall bursts
         if (holds_asked != holds_done) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         next_stall = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            next_stall = 1'b1;
         end
         rsp_stall <= next_stall;
      end
   end

   // ---------------------------------------------------------------
   // watchdog: cycles with no transaction on any port
   // ---------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d of %0d bytes taken, %0d results pending",
                     chars_taken, chars_queued, expected_scores.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   task automatic write_register(input fss_pkg::reg_index_type idx,
                                 input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == fss_pkg::REG_PATTERN_LENGTH) pattern_len = value[5:0];
      else pattern_words[int'(idx) - 1] = value;
   endtask

   // waits until every byte is in and every score is out, plus a margin
   task automatic drain();
      while (chars_taken != chars_queued || expected_scores.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_chars(input logic [7:0] txt [$], input bit with_last);
      fss_pkg::req_payload_type item;
      foreach (txt[i]) begin
         item.text_char  = txt[i];
         item.last_char  = with_last && (i == txt.size() - 1);
         item.empty_text = 1'b0;
         pending_chars = {pending_chars, item};
         chars_queued++;
      end
   endtask

   task automatic queue_empty(input bit with_last);
      fss_pkg::req_payload_type item;
      item.text_char  = 8'($urandom_range(0, 255));
      item.last_char  = with_last;
      item.empty_text = 1'b1;
      pending_chars = {pending_chars, item};
      chars_queued++;
   endtask

   task automatic queue_string(input string s);
      logic [7:0] txt [$];
      for (int i = 0; i < s.len(); i++) txt = {txt, s[i]};
      queue_chars(txt, 1'b1);
   endtask

   function automatic logic [7:0] case_variant(input logic [7:0] c);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) return c - 8'd32;
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) return c + 8'd32;
      return c;
   endfunction

   // mostly a small alphabet so that matches are common, sometimes any byte
   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return ALPHABET[$urandom_range(0, ALPHABET.len() - 1)];
   endfunction

   task automatic queue_random_text();
      logic [7:0] txt [$];
      int         m;
      int         pick;
      m = used_length();
      pick = $urandom_range(0, 59);
      if (pick < 15) begin
         // whole pattern, random case
         for (int k = 0; k < m; k++) txt = {txt, case_variant(pattern_char(k))};
      end else if (pick < 30) begin
         // pattern inside random context
         repeat ($urandom_range(0, 4)) txt = {txt, pick_char()};
         for (int k = 0; k < m; k++) txt = {txt, case_variant(pattern_char(k))};
         repeat ($urandom_range(0, 4)) txt = {txt, pick_char()};
      end else if (pick < 45) begin
         // pattern spread out with filler between hits
         for (int k = 0; k < m; k++) begin
            repeat ($urandom_range(0, 2)) txt = {txt, pick_char()};
            txt = {txt, case_variant(pattern_char(k))};
         end
         repeat ($urandom_range(0, 2)) txt = {txt, pick_char()};
      end else if (pick < 50) begin
         repeat ($urandom_range(1, 12)) txt = {txt, pick_char()};
      end else if (pick < 54) begin
         repeat ($urandom_range(1, 8)) txt = {txt, 8'($urandom_range(0, 255))};
      end else if (pick < 57) begin
         // text cut short by the empty flag
         repeat ($urandom_range(1, 5)) txt = {txt, pick_char()};
         queue_chars(txt, 1'b0);
         queue_empty($urandom_range(0, 1));
         return;
      end else if (pick < 59) begin
         queue_empty($urandom_range(0, 1));
         return;
      end else begin
         // long enough to saturate the position count
         repeat ($urandom_range(64, 80)) txt = {txt, pick_char()};
      end
      if (txt.size() == 0) txt = {txt, pick_char()};
      queue_chars(txt, 1'b1);
   endtask

   function automatic logic [63:0] random_pattern_word();
      logic [63:0] w;
      for (int b = 0; b < 8; b++)
         w[b*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : ALPHABET[$urandom_range(0, 9)];
      return w;
   endfunction

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   logic [5:0] new_len;
   int         phase;
   int         phase_start;
   bit         last_phase;

   initial begin
      restart_text();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed list against the pattern "Ab/c"
      write_register(fss_pkg::REG_PATTERN_LENGTH, 64'd4);
      write_register(fss_pkg::REG_PATTERN_WORD_0, {32'($urandom), 32'h632F_6241});
      write_register(fss_pkg::REG_PATTERN_WORD_1, {32'($urandom), 32'($urandom)});
      write_register(fss_pkg::REG_PATTERN_WORD_2, 64'hFFFF_FFFF_FFFF_FFFF);
      write_register(fss_pkg::REG_PATTERN_WORD_3, 64'h0);
      settings_used++;
      @(negedge clock);
      queue_empty(1'b1);            // empty flag wins over last_char
      queue_string("aB/C");         // exact, case folded
      queue_string("xxab/cz");      // contiguous substring
      queue_string("a-b/zc");       // subsequence with boundary and adjacency
      queue_string("zzz");          // no match
      queue_string("ab/cab/c");     // substring longer than the pattern
      begin
         logic [7:0] part [$];
         part = '{8'h61, 8'h62};
         queue_chars(part, 1'b0);   // partial text dropped by the empty flag
         queue_empty(1'b0);
         part = '{8'h00, 8'hFF};
         queue_chars(part, 1'b1);   // byte extremes
      end
      drain();

      // random phases, each under a fresh pattern setting
      phase = 1;
      last_phase = 1'b0;
      while (!last_phase) begin
         case (phase)
            1: new_len = 6'd0;       // empty pattern
            2: new_len = 6'd63;      // largest length, clipped to full store
            3: new_len = 6'd32;
            4: new_len = 6'd1;
            5: new_len = 6'd40;
            default: new_len = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                          : 6'($urandom_range(1, 8));
         endcase
         write_register(fss_pkg::REG_PATTERN_LENGTH, {58'($urandom), new_len});
         write_register(fss_pkg::REG_PATTERN_WORD_0, random_pattern_word());
         write_register(fss_pkg::REG_PATTERN_WORD_1, random_pattern_word());
         write_register(fss_pkg::REG_PATTERN_WORD_2, random_pattern_word());
         write_register(fss_pkg::REG_PATTERN_WORD_3, random_pattern_word());
         settings_used++;
         @(negedge clock);
         // the final phase tops the run up to the target at full rate
         last_phase = chars_queued + 2 * PHASE_ITEMS > ITEM_TARGET;
         req_gaps_on = !last_phase;
         rsp_stalls_on = !last_phase;
         phase_start = chars_queued;
         while (last_phase ? chars_queued < ITEM_TARGET
                           : chars_queued - phase_start < PHASE_ITEMS)
            queue_random_text();
         // fill the block while the receiver holds off
         if (phase == 7) holds_asked++;
         drain();
         phase++;
      end

      $display("%0d bytes in %0d results under %0d pattern settings", chars_taken,
               results_checked, settings_used);
      $display("kinds seen: none %0d, subsequence %0d, substring %0d, exact %0d",
               kind_seen[fss_pkg::KIND_NONE], kind_seen[fss_pkg::KIND_SUBSEQUENCE],
               kind_seen[fss_pkg::KIND_SUBSTRING], kind_seen[fss_pkg::KIND_EXACT]);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
